// ===== rtl/gfbs_pkg.sv =====
package gfbs_pkg;

  localparam int unsigned STACK_DEPTH_DEF    = 32;
  localparam int unsigned BLOCK_NUM_BITS_DEF = 24;
  localparam int unsigned OPCODE_W           = 2;
  localparam int unsigned KIND_W             = 2;

  typedef enum logic [OPCODE_W-1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_FILL  = 2'd2
  } opcode_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_ALLOC = 2'd0,
    KIND_FREED = 2'd1,
    KIND_SPILL = 2'd2,
    KIND_ERROR = 2'd3
  } kind_e;

  // cell shift: DOWN moves entries away from the top, UP pops toward it
  typedef enum logic [1:0] {
    SH_HOLD = 2'd0,
    SH_DOWN = 2'd1,
    SH_UP   = 2'd2
  } shift_e;

  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_SPILL = 1'b1
  } state_e;

endpackage

// ===== rtl/gfbs_cell.sv =====
module gfbs_cell #(
  parameter int unsigned BLOCK_NUM_BITS = gfbs_pkg::BLOCK_NUM_BITS_DEF
) (
  input  logic                      clk_i,
  input  gfbs_pkg::shift_e          shift_op_i,
  input  logic [BLOCK_NUM_BITS-1:0] from_up_i,
  input  logic [BLOCK_NUM_BITS-1:0] from_down_i,
  output logic [BLOCK_NUM_BITS-1:0] entry_o
);

  logic [BLOCK_NUM_BITS-1:0] entry_q, entry_d;

  always_comb begin
    case (shift_op_i)
      gfbs_pkg::SH_DOWN: entry_d = from_up_i;
      gfbs_pkg::SH_UP:   entry_d = from_down_i;
      default:           entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

// ===== rtl/gfbs_ctrl.sv =====
module gfbs_ctrl #(
  parameter int unsigned STACK_DEPTH    = gfbs_pkg::STACK_DEPTH_DEF,
  parameter int unsigned BLOCK_NUM_BITS = gfbs_pkg::BLOCK_NUM_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_valid_i,
  output logic                            s_ready_o,
  input  logic [gfbs_pkg::OPCODE_W-1:0]   opcode_i,
  input  logic [BLOCK_NUM_BITS-1:0]       block_number_i,
  input  logic [BLOCK_NUM_BITS-1:0]       fill_entry_i,
  input  logic [BLOCK_NUM_BITS-1:0]       top_entry_i,
  input  logic [BLOCK_NUM_BITS-1:0]       bottom_entry_i,
  output gfbs_pkg::shift_e                shift_op_o,
  output logic [BLOCK_NUM_BITS-1:0]       shift_data_o,
  output logic                            m_valid_o,
  input  logic                            m_ready_i,
  output logic [gfbs_pkg::KIND_W-1:0]     kind_o,
  output logic [BLOCK_NUM_BITS-1:0]       result_block_o,
  output logic [BLOCK_NUM_BITS-1:0]       spill_entry_o,
  output logic                            fill_request_o,
  output logic                            last_o
);

  localparam int unsigned CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int unsigned IDX_W = $clog2(STACK_DEPTH);

  gfbs_pkg::state_e state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             reloading_q, reloading_d;
  logic [IDX_W-1:0] reload_idx_q, reload_idx_d;
  logic [IDX_W-1:0] spill_cnt_q, spill_cnt_d;
  logic             m_valid_q, m_valid_d;

  logic [BLOCK_NUM_BITS-1:0] spill_blk_q, spill_blk_d;
  gfbs_pkg::kind_e           res_kind_q, res_kind_d;
  logic [BLOCK_NUM_BITS-1:0] res_block_q, res_block_d;
  logic [BLOCK_NUM_BITS-1:0] res_spill_q, res_spill_d;
  logic                      res_fill_q, res_fill_d;
  logic                      res_last_q, res_last_d;

  logic out_free;
  logic take;

  assign out_free  = !m_valid_q || m_ready_i;
  assign s_ready_o = (state_q == gfbs_pkg::ST_IDLE) && out_free;
  assign take      = s_valid_i && s_ready_o;

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    reloading_d  = reloading_q;
    reload_idx_d = reload_idx_q;
    spill_cnt_d  = spill_cnt_q;
    spill_blk_d  = spill_blk_q;
    m_valid_d    = m_valid_q && !m_ready_i;
    res_kind_d   = res_kind_q;
    res_block_d  = res_block_q;
    res_spill_d  = res_spill_q;
    res_fill_d   = res_fill_q;
    res_last_d   = res_last_q;
    shift_op_o   = gfbs_pkg::SH_HOLD;
    shift_data_o = block_number_i;

    case (state_q)
      gfbs_pkg::ST_IDLE: begin
        if (take) begin
          // error result unless an arm below says otherwise
          m_valid_d   = 1'b1;
          res_kind_d  = gfbs_pkg::KIND_ERROR;
          res_block_d = '0;
          res_spill_d = '0;
          res_fill_d  = 1'b0;
          res_last_d  = 1'b1;
          case (opcode_i)
            gfbs_pkg::OP_ALLOC: begin
              if (!reloading_q && count_q != '0) begin
                res_kind_d  = gfbs_pkg::KIND_ALLOC;
                res_block_d = top_entry_i;
                shift_op_o  = gfbs_pkg::SH_UP;
                count_d     = count_q - CNT_W'(1);
                if (count_q == CNT_W'(1)) begin
                  res_fill_d   = 1'b1;
                  reloading_d  = 1'b1;
                  reload_idx_d = '0;
                end
              end
            end
            gfbs_pkg::OP_FREE: begin
              if (!reloading_q) begin
                if (count_q == CNT_W'(STACK_DEPTH)) begin
                  m_valid_d   = m_valid_q && !m_ready_i;
                  spill_blk_d = block_number_i;
                  spill_cnt_d = '0;
                  state_d     = gfbs_pkg::ST_SPILL;
                end else begin
                  res_kind_d = gfbs_pkg::KIND_FREED;
                  shift_op_o = gfbs_pkg::SH_DOWN;
                  count_d    = count_q + CNT_W'(1);
                end
              end
            end
            gfbs_pkg::OP_FILL: begin
              if (reloading_q) begin
                m_valid_d    = m_valid_q && !m_ready_i;
                shift_op_o   = gfbs_pkg::SH_DOWN;
                shift_data_o = fill_entry_i;
                reload_idx_d = reload_idx_q + IDX_W'(1);
                if (reload_idx_q == IDX_W'(STACK_DEPTH - 1)) begin
                  count_d      = CNT_W'(STACK_DEPTH);
                  reloading_d  = 1'b0;
                  reload_idx_d = '0;
                end
              end
            end
            default: ;
          endcase
        end
      end
      gfbs_pkg::ST_SPILL: begin
        if (out_free) begin
          // bottom cell leaves first; the freed block fills in behind
          m_valid_d    = 1'b1;
          res_kind_d   = gfbs_pkg::KIND_SPILL;
          res_block_d  = spill_blk_q;
          res_spill_d  = bottom_entry_i;
          res_fill_d   = 1'b0;
          res_last_d   = 1'b0;
          shift_op_o   = gfbs_pkg::SH_DOWN;
          shift_data_o = spill_blk_q;
          spill_cnt_d  = spill_cnt_q + IDX_W'(1);
          if (spill_cnt_q == IDX_W'(STACK_DEPTH - 1)) begin
            res_last_d  = 1'b1;
            count_d     = CNT_W'(1);
            spill_cnt_d = '0;
            state_d     = gfbs_pkg::ST_IDLE;
          end
        end
      end
      default: state_d = gfbs_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= gfbs_pkg::ST_IDLE;
      count_q      <= '0;
      reloading_q  <= 1'b0;
      reload_idx_q <= '0;
      spill_cnt_q  <= '0;
      m_valid_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      reloading_q  <= reloading_d;
      reload_idx_q <= reload_idx_d;
      spill_cnt_q  <= spill_cnt_d;
      m_valid_q    <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    spill_blk_q <= spill_blk_d;
    res_kind_q  <= res_kind_d;
    res_block_q <= res_block_d;
    res_spill_q <= res_spill_d;
    res_fill_q  <= res_fill_d;
    res_last_q  <= res_last_d;
  end

  assign m_valid_o      = m_valid_q;
  assign kind_o         = res_kind_q;
  assign result_block_o = res_block_q;
  assign spill_entry_o  = res_spill_q;
  assign fill_request_o = res_fill_q;
  assign last_o         = res_last_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(STACK_DEPTH))
    else $error("stack count above depth");

  a_reload_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    reloading_q |-> (count_q == '0))
    else $error("stack not empty during reload");

  a_spill_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == gfbs_pkg::ST_SPILL) |-> (count_q == CNT_W'(STACK_DEPTH) && !s_ready_o))
    else $error("spill without full stack or with input open");

  a_spill_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == gfbs_pkg::ST_SPILL && state_d == gfbs_pkg::ST_IDLE) |=>
      (m_valid_q && res_last_q && count_q == CNT_W'(1)))
    else $error("spill did not end with last word and one entry");

  a_alloc_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && opcode_i == gfbs_pkg::OP_ALLOC && !reloading_q && count_q == CNT_W'(1))
      |=> (reloading_q && res_fill_q))
    else $error("emptying allocation did not start reload");

endmodule

// ===== rtl/grouped_free_block_stack_top.sv =====
// Channel   Dir  tdata (low bit up)                          tuser    tlast
// s_axis    in   block_number, fill_entry, zero pad          opcode   -
// m_axis    out  result_block, spill_entry, fill_request,    kind     last
//                zero pad
// Allocate, free and fill requests are taken one per cycle while the result
// side is ready and no spill runs. A full-stack free streams STACK_DEPTH
// spill words, one per cycle unless the result side stalls, as the cell
// chain shifts toward the bottom cell. Reset clears count and reload state;
// cell contents are undefined until written. A stalled result holds the
// input side only once the output register is occupied.
module grouped_free_block_stack_top #(
  parameter int unsigned STACK_DEPTH    = gfbs_pkg::STACK_DEPTH_DEF,
  parameter int unsigned BLOCK_NUM_BITS = gfbs_pkg::BLOCK_NUM_BITS_DEF,
  localparam int unsigned IN_DATA_W     = ((2 * BLOCK_NUM_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_DATA_W    = ((2 * BLOCK_NUM_BITS + 1 + 7) / 8) * 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // block_number, fill_entry
  input  logic [IN_DATA_W-1:0]          s_axis_tdata_i,
  // opcode
  input  logic [gfbs_pkg::OPCODE_W-1:0] s_axis_tuser_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // result_block, spill_entry, fill_request
  output logic [OUT_DATA_W-1:0]         m_axis_tdata_o,
  // kind
  output logic [gfbs_pkg::KIND_W-1:0]   m_axis_tuser_o,
  output logic                          m_axis_tlast_o
);

  localparam int unsigned B = BLOCK_NUM_BITS;

  gfbs_pkg::shift_e shift_op;
  logic [B-1:0]     shift_data;
  logic [B-1:0]     entry [STACK_DEPTH];
  logic [B-1:0]     result_block;
  logic [B-1:0]     spill_entry;
  logic             fill_request;

  gfbs_ctrl #(
    .STACK_DEPTH   (STACK_DEPTH),
    .BLOCK_NUM_BITS(B)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_valid_i     (s_axis_tvalid_i),
    .s_ready_o     (s_axis_tready_o),
    .opcode_i      (s_axis_tuser_i),
    .block_number_i(s_axis_tdata_i[B-1:0]),
    .fill_entry_i  (s_axis_tdata_i[2*B-1:B]),
    .top_entry_i   (entry[0]),
    .bottom_entry_i(entry[STACK_DEPTH-1]),
    .shift_op_o    (shift_op),
    .shift_data_o  (shift_data),
    .m_valid_o     (m_axis_tvalid_o),
    .m_ready_i     (m_axis_tready_i),
    .kind_o        (m_axis_tuser_o),
    .result_block_o(result_block),
    .spill_entry_o (spill_entry),
    .fill_request_o(fill_request),
    .last_o        (m_axis_tlast_o)
  );

  // cell 0 is the top of stack
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [B-1:0] from_up;
    logic [B-1:0] from_down;
    if (i == 0) begin : g_top
      assign from_up = shift_data;
    end else begin : g_mid
      assign from_up = entry[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_bot
      assign from_down = entry[i];
    end else begin : g_above
      assign from_down = entry[i+1];
    end
    gfbs_cell #(
      .BLOCK_NUM_BITS(B)
    ) u_cell (
      .clk_i      (clk_i),
      .shift_op_i (shift_op),
      .from_up_i  (from_up),
      .from_down_i(from_down),
      .entry_o    (entry[i])
    );
  end

  assign m_axis_tdata_o = {{(OUT_DATA_W - 2 * B - 1){1'b0}}, fill_request, spill_entry,
                           result_block};

endmodule
